@@ hw/rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the tilt stabilizer
// Arctangent table, divider request/status types, register codes, saturation.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int CalSamplesDef = 200;
	localparam int AngleFracDef  = 16;
	localparam int CordicSteps   = 24;
	localparam int DivW          = 64;
	localparam int DenW          = 17;

	localparam logic [DenW-1:0] DenGyro  = 17'd131000;
	localparam logic [DenW-1:0] DenMilli = 17'd1000;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115
	};

	// configuration register codes
	localparam logic [2:0] RegGainProp   = 3'd0;
	localparam logic [2:0] RegGainInteg  = 3'd1;
	localparam logic [2:0] RegGainDeriv  = 3'd2;
	localparam logic [2:0] RegBlend      = 3'd3;
	localparam logic [2:0] RegServoLow   = 3'd4;
	localparam logic [2:0] RegServoHigh  = 3'd5;

	localparam logic [15:0] GainPropRst  = 16'd768;
	localparam logic [15:0] GainIntegRst = 16'd128;
	localparam logic [15:0] GainDerivRst = 16'd26;
	localparam logic [15:0] BlendRst     = 16'd62915;
	localparam logic [7:0]  ServoLowRst  = 8'd30;
	localparam logic [7:0]  ServoHighRst = 8'd120;

	typedef struct packed {
		logic                   start;
		logic signed [DivW-1:0] num;
		logic [DenW-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

@@ hw/rtl/tsp_div.sv @@
// ----------------------------------------------------------------------------
// tsp_div: iterative rounding divider
// Signed numerator by unsigned divisor, rounded half away from zero, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsp_pkg::div_req_t            req,
	output tsp_pkg::unit_stat_t          stat,
	output logic signed [tsp_pkg::DivW-1:0] quot
);
	import tsp_pkg::*;

	localparam int CntW = $clog2(DivW);

	logic            busy_q, done_q, neg_q;
	logic [DivW-1:0] dvd_q;
	logic [DenW-1:0] den_q;
	logic [DenW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0]   trial;
	logic            fits;
	logic [DivW-1:0] mag;

	always_comb begin
		trial = {rem_q, dvd_q[DivW-1]};
		fits  = trial >= {1'b0, den_q};
		mag   = req.num[DivW-1] ? DivW'(-req.num) : DivW'(req.num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) busy_q <= 1'b0;
			end
		end
	end

	// dividend register turns into the quotient as bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[DivW-1];
			dvd_q <= mag + DivW'(req.den >> 1);
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
			dvd_q <= {dvd_q[DivW-2:0], fits};
		end
	end

	assign quot      = neg_q ? -signed'(dvd_q) : signed'(dvd_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ hw/rtl/tsp_tilt.sv @@
// ----------------------------------------------------------------------------
// tsp_tilt: accelerometer tilt angle
// Bit-serial square root of the sum of squares, then a 24-step CORDIC
// arctangent, one step per cycle; a zero numerator skips the CORDIC.
// ----------------------------------------------------------------------------
module tsp_tilt #(
	parameter int ANGLE_FRAC_BITS = tsp_pkg::AngleFracDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         sq,
	input  logic signed [16:0]  num,
	output tsp_pkg::unit_stat_t stat,
	output logic signed [31:0]  angle
);
	import tsp_pkg::*;

	localparam int RndSh  = CordicSteps - ANGLE_FRAC_BITS;
	localparam int RndPos = (RndSh > 0) ? RndSh - 1 : 0;
	localparam logic signed [32:0] RndAdd = (RndSh > 0) ? (33'sd1 <<< RndPos) : 33'sd0;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_ROOT = 3'b010,
		T_ROT  = 3'b100
	} tilt_st_t;

	tilt_st_t           st_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	logic [63:0]        n_q, r_q, bit_q;
	logic signed [35:0] x_q, y_q;
	logic signed [31:0] z_q, angle_q;

	logic [63:0]        root_t, r_next;
	logic               root_ge, y_pos;
	logic signed [35:0] dx, dy;
	logic signed [31:0] z_next;
	logic signed [32:0] z_rnd;

	always_comb begin
		root_t  = r_q + bit_q;
		root_ge = n_q >= root_t;
		r_next  = root_ge ? (r_q >> 1) + bit_q : r_q >> 1;
		dx      = y_q >>> cnt_q;
		dy      = x_q >>> cnt_q;
		y_pos   = !y_q[35] && (y_q != '0);
		z_next  = y_pos ? z_q + signed'(ATAN_TAB[cnt_q]) : z_q - signed'(ATAN_TAB[cnt_q]);
		z_rnd   = (33'(z_next) + RndAdd) >>> RndSh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= T_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ((st_q == T_ROOT) && (cnt_q == 5'd31) && (y_q == '0)) ||
				((st_q == T_ROT) && (cnt_q == 5'(CordicSteps - 1)));
			unique case (st_q)
				T_IDLE: begin
					cnt_q <= '0;
					if (start) st_q <= T_ROOT;
				end
				T_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						// zero numerator: angle is exactly zero
						st_q <= (y_q == '0) ? T_IDLE : T_ROT;
					end
				end
				T_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(CordicSteps - 1)) st_q <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			T_IDLE: begin
				n_q   <= {sq, 32'h0};
				r_q   <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				y_q   <= 36'(signed'({num, 16'h0}));
				z_q   <= '0;
			end
			T_ROOT: begin
				if (root_ge) n_q <= n_q - root_t;
				r_q   <= r_next;
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					x_q <= signed'({3'b000, r_next[32:0]});
					if (y_q == '0) angle_q <= '0;
				end
			end
			T_ROT: begin
				x_q <= y_pos ? x_q + dx : x_q - dx;
				y_q <= y_pos ? y_q - dy : y_q + dy;
				z_q <= z_next;
				if (cnt_q == 5'(CordicSteps - 1)) angle_q <= z_rnd[31:0];
			end
			default: ;
		endcase
	end

	assign stat.busy = (st_q != T_IDLE);
	assign stat.done = done_q;
	assign angle     = angle_q;

endmodule

@@ hw/rtl/tilt_stabilizer_pid_core.sv @@
// ----------------------------------------------------------------------------
// tilt_stabilizer_pid_core: two-axis tilt stabilizer
// Accelerometer tilt, gyro integration, complementary filter and PID per axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream takes one raw sensor sample per request. The first CAL_SAMPLES
//   requests only calibrate the angle and gyro offsets and give no result.
//   Each later request gives one m_* result: two servo positions and the
//   filtered roll and pitch angles.
//   cfg_* writes gain, blend and limit registers; cfg_ready is always high.
//   Write only while the block is idle.
// Schedule:
//   One sample at a time. Each axis runs the tilt unit (square root plus
//   CORDIC, which a zero numerator skips); the last calibration sample adds
//   four divides. A control sample runs the 64-step divider three times
//   per axis; zero elapsed time skips the derivative divide. One shared
//   48x18 multiplier does all products.
// Reset: gains and limits go to their defaults, calibration restarts.
// A stalled m_tready holds the result; the next sample is still taken and
// waits in its final state until the output register frees up.
// ----------------------------------------------------------------------------
module tilt_stabilizer_pid_core #(
	parameter int CAL_SAMPLES     = tsp_pkg::CalSamplesDef,
	parameter int ANGLE_FRAC_BITS = tsp_pkg::AngleFracDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms (16 bits each)
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// servo_x_pos[7:0], servo_y_pos[15:8], roll_angle[47:16], pitch_angle[79:48]
	output logic [79:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tsp_pkg::*;

	localparam int PosSh = ANGLE_FRAC_BITS + 8;
	localparam logic signed [65:0] PosBias = 66'sd90 <<< PosSh;

	typedef enum logic [25:0] {
		ST_IDLE  = 26'h0000001,
		ST_SQA   = 26'h0000002,
		ST_SQB   = 26'h0000004,
		ST_SQS   = 26'h0000008,
		ST_TILT  = 26'h0000010,
		ST_CAL   = 26'h0000020,
		ST_ODIV  = 26'h0000040,
		ST_OWAIT = 26'h0000080,
		ST_GMUL  = 26'h0000100,
		ST_GDIV  = 26'h0000200,
		ST_GWAIT = 26'h0000400,
		ST_BMUL  = 26'h0000800,
		ST_BMUL2 = 26'h0001000,
		ST_BSUM  = 26'h0002000,
		ST_IMUL  = 26'h0004000,
		ST_IDIV  = 26'h0008000,
		ST_IWAIT = 26'h0010000,
		ST_DMUL  = 26'h0020000,
		ST_DDIV  = 26'h0040000,
		ST_DWAIT = 26'h0080000,
		ST_PMUL  = 26'h0100000,
		ST_PIMUL = 26'h0200000,
		ST_PDMUL = 26'h0400000,
		ST_PACC  = 26'h0800000,
		ST_PFIN  = 26'h1000000,
		ST_DONE  = 26'h2000000
	} core_st_t;

	core_st_t state_q;
	logic     k_q;
	logic [1:0] oj_q;

	// configuration
	logic [15:0] gain_prop_q, gain_integ_q, gain_deriv_q, blend_weight_q;
	logic [7:0]  servo_low_q, servo_high_q;

	// calibration and filter state
	logic [7:0]         cal_count_q;
	logic signed [39:0] asum_q [2];
	logic signed [23:0] gsum_q [2];
	logic signed [31:0] aoff_q [2];
	logic signed [15:0] goff_q [2];
	logic signed [31:0] gang_q [2];
	logic signed [31:0] integ_q [2];
	logic signed [31:0] last_q [2];

	// per-sample working registers
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [15:0]        ms_q;
	logic signed [31:0] ang_q [2];
	logic signed [65:0] mul_q, acc_q;
	logic signed [31:0] g_q, err_q;
	logic signed [43:0] deriv_q;
	logic [7:0]         servo_q [2];
	logic signed [31:0] est_q [2];
	logic [79:0]        out_q;
	logic               m_tvalid_q;

	// shared units
	logic signed [47:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [65:0] mul_p;
	div_req_t           div_req;
	unit_stat_t         div_stat, tilt_stat;
	logic signed [63:0] div_quot;
	logic               tilt_start;
	logic [31:0]        tilt_sq;
	logic signed [16:0] tilt_num;
	logic signed [31:0] tilt_angle;

	// datapath terms
	logic signed [15:0] tl_a, tl_b, gsel;
	logic signed [16:0] rate;
	logic signed [32:0] acc_ang, err_diff;
	logic signed [65:0] blend_sum, pos_w;
	logic signed [31:0] est, err_new;
	logic [7:0]         pos_clamp;

	always_comb begin
		tl_a      = k_q ? ay_q : ax_q;
		tl_b      = az_q;
		tilt_num  = k_q ? -17'(ax_q) : 17'(ay_q);
		tilt_sq   = acc_q[31:0] + mul_q[31:0];
		tilt_start = (state_q == ST_SQS);
		gsel      = k_q ? gy_q : gx_q;
		rate      = 17'(gsel) - 17'(goff_q[k_q]);
		acc_ang   = 33'(ang_q[k_q]) - 33'(aoff_q[k_q]);
		err_diff  = 33'(err_q) - 33'(last_q[k_q]);
		blend_sum = acc_q + mul_q;
		est       = sat32((blend_sum + 66'sd32768) >>> 16);
		err_new   = sat32(-66'(est));
		pos_w     = (acc_q + PosBias) >>> PosSh;
		if (pos_w < signed'({58'h0, servo_low_q})) pos_clamp = servo_low_q;
		else if (pos_w > signed'({58'h0, servo_high_q})) pos_clamp = servo_high_q;
		else pos_clamp = pos_w[7:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQA: begin
				mul_a = 48'(tl_a);
				mul_b = 18'(tl_a);
			end
			ST_SQB: begin
				mul_a = 48'(tl_b);
				mul_b = 18'(tl_b);
			end
			ST_GMUL: begin
				mul_a = 48'(rate);
				mul_b = signed'({2'b00, ms_q});
			end
			ST_BMUL: begin
				mul_a = 48'(g_q);
				mul_b = signed'({2'b00, blend_weight_q});
			end
			ST_BMUL2: begin
				mul_a = 48'(acc_ang);
				mul_b = 18'sd65536 - signed'({2'b00, blend_weight_q});
			end
			ST_IMUL: begin
				mul_a = 48'(err_q);
				mul_b = signed'({2'b00, ms_q});
			end
			ST_DMUL: begin
				mul_a = 48'(err_diff);
				mul_b = 18'sd1000;
			end
			ST_PMUL: begin
				mul_a = 48'(err_q);
				mul_b = signed'({2'b00, gain_prop_q});
			end
			ST_PIMUL: begin
				mul_a = 48'(integ_q[k_q]);
				mul_b = signed'({2'b00, gain_integ_q});
			end
			ST_PDMUL: begin
				mul_a = 48'(deriv_q);
				mul_b = signed'({2'b00, gain_deriv_q});
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = signed'(mul_q[63:0]);
		div_req.den   = DenMilli;
		unique case (state_q)
			ST_ODIV: begin
				div_req.start = 1'b1;
				div_req.den   = DenW'(CAL_SAMPLES);
				unique case (oj_q)
					2'd0: div_req.num = 64'(asum_q[0]);
					2'd1: div_req.num = 64'(asum_q[1]);
					2'd2: div_req.num = 64'(gsum_q[0]);
					default: div_req.num = 64'(gsum_q[1]);
				endcase
			end
			ST_GDIV: begin
				div_req.start = 1'b1;
				div_req.num   = signed'(mul_q[63:0]) <<< ANGLE_FRAC_BITS;
				div_req.den   = DenGyro;
			end
			ST_IDIV: div_req.start = 1'b1;
			ST_DDIV: begin
				div_req.start = (ms_q != '0);
				div_req.den   = {1'b0, ms_q};
			end
			default: ;
		endcase
	end

	tsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	tsp_tilt #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tilt_start),
		.sq     (tilt_sq),
		.num    (tilt_num),
		.stat   (tilt_stat),
		.angle  (tilt_angle)
	);

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= 1'b0;
			oj_q           <= '0;
			m_tvalid_q     <= 1'b0;
			gain_prop_q    <= GainPropRst;
			gain_integ_q   <= GainIntegRst;
			gain_deriv_q   <= GainDerivRst;
			blend_weight_q <= BlendRst;
			servo_low_q    <= ServoLowRst;
			servo_high_q   <= ServoHighRst;
			cal_count_q    <= '0;
			for (int i = 0; i < 2; i++) begin
				asum_q[i]  <= '0;
				gsum_q[i]  <= '0;
				aoff_q[i]  <= '0;
				goff_q[i]  <= '0;
				gang_q[i]  <= '0;
				integ_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					RegGainProp:  gain_prop_q    <= cfg_data;
					RegGainInteg: gain_integ_q   <= cfg_data;
					RegGainDeriv: gain_deriv_q   <= cfg_data;
					RegBlend:     blend_weight_q <= cfg_data;
					RegServoLow:  servo_low_q    <= cfg_data[7:0];
					RegServoHigh: servo_high_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					k_q <= 1'b0;
					if (s_tvalid) state_q <= ST_SQA;
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_TILT;
				ST_TILT: begin
					if (tilt_stat.done) begin
						if (!k_q) begin
							k_q     <= 1'b1;
							state_q <= ST_SQA;
						end else begin
							k_q     <= 1'b0;
							state_q <= (cal_count_q < 8'(CAL_SAMPLES)) ? ST_CAL : ST_GMUL;
						end
					end
				end
				ST_CAL: begin
					asum_q[0]   <= asum_q[0] + 40'(ang_q[0]);
					asum_q[1]   <= asum_q[1] + 40'(ang_q[1]);
					gsum_q[0]   <= gsum_q[0] + 24'(gx_q);
					gsum_q[1]   <= gsum_q[1] + 24'(gy_q);
					cal_count_q <= cal_count_q + 1'b1;
					oj_q        <= '0;
					state_q     <= (cal_count_q == 8'(CAL_SAMPLES - 1)) ? ST_ODIV : ST_IDLE;
				end
				ST_ODIV: state_q <= ST_OWAIT;
				ST_OWAIT: begin
					if (div_stat.done) begin
						unique case (oj_q)
							2'd0: aoff_q[0] <= sat32(66'(div_quot));
							2'd1: aoff_q[1] <= sat32(66'(div_quot));
							2'd2: goff_q[0] <= div_quot[15:0];
							default: goff_q[1] <= div_quot[15:0];
						endcase
						oj_q    <= oj_q + 1'b1;
						state_q <= (oj_q == 2'd3) ? ST_IDLE : ST_ODIV;
					end
				end
				ST_GMUL:  state_q <= ST_GDIV;
				ST_GDIV:  state_q <= ST_GWAIT;
				ST_GWAIT: if (div_stat.done) state_q <= ST_BMUL;
				ST_BMUL:  state_q <= ST_BMUL2;
				ST_BMUL2: state_q <= ST_BSUM;
				ST_BSUM: begin
					gang_q[k_q] <= est;
					state_q     <= ST_IMUL;
				end
				ST_IMUL: state_q <= ST_IDIV;
				ST_IDIV: state_q <= ST_IWAIT;
				ST_IWAIT: begin
					if (div_stat.done) begin
						integ_q[k_q] <= sat32(66'(integ_q[k_q]) + 66'(div_quot));
						state_q      <= ST_DMUL;
					end
				end
				ST_DMUL: state_q <= ST_DDIV;
				// no elapsed time: derivative is zero, skip the divide
				ST_DDIV: state_q <= (ms_q == '0) ? ST_PMUL : ST_DWAIT;
				ST_DWAIT: if (div_stat.done) state_q <= ST_PMUL;
				ST_PMUL: begin
					last_q[k_q] <= err_q;
					state_q     <= ST_PIMUL;
				end
				ST_PIMUL: state_q <= ST_PDMUL;
				ST_PDMUL: state_q <= ST_PACC;
				ST_PACC:  state_q <= ST_PFIN;
				ST_PFIN: begin
					k_q     <= 1'b1;
					state_q <= k_q ? ST_DONE : ST_GMUL;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				ax_q <= signed'(s_tdata[15:0]);
				ay_q <= signed'(s_tdata[31:16]);
				az_q <= signed'(s_tdata[47:32]);
				gx_q <= signed'(s_tdata[63:48]);
				gy_q <= signed'(s_tdata[79:64]);
				ms_q <= s_tdata[95:80];
			end
			ST_SQB: acc_q <= mul_q;
			ST_TILT: if (tilt_stat.done) ang_q[k_q] <= tilt_angle;
			ST_GWAIT: g_q <= sat32(66'(gang_q[k_q]) + 66'(div_quot));
			ST_BMUL2: acc_q <= mul_q;
			ST_BSUM: begin
				est_q[k_q] <= est;
				err_q      <= err_new;
			end
			ST_DDIV: if (ms_q == '0) deriv_q <= '0;
			ST_DWAIT: if (div_stat.done) deriv_q <= div_quot[43:0];
			ST_PIMUL: acc_q <= mul_q;
			ST_PDMUL: acc_q <= acc_q + mul_q;
			ST_PACC:  acc_q <= acc_q + mul_q;
			ST_PFIN:  servo_q[k_q] <= pos_clamp;
			ST_DONE: begin
				if (!m_tvalid_q || m_tready)
					out_q <= {est_q[1], est_q[0], servo_q[1], servo_q[0]};
			end
			default: ;
		endcase
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;

`ifndef SYNTHESIS
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_tilt_free: assert property (@(posedge clk) disable iff (!arst_n)
		tilt_start |-> !tilt_stat.busy)
		else $error("tilt unit started while busy");
	a_cal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q <= 8'(CAL_SAMPLES))
		else $error("calibration count past its end");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");
`endif

endmodule
